// ===== src/cgl_pkg.sv =====
// Package for the channel-group layout address generator.
// Holds widths, size bounds, register indexes, clamp helpers and pipeline
// stage types; no dependencies.
package cgl_pkg;

   localparam int INDEX_BITS = 32;
   localparam int DIM_BITS   = 12;

   localparam int BATCH_W   = 16;
   localparam int CHAN_W    = 13;
   localparam int DIM_W     = DIM_BITS + 1;
   localparam int GSIZE_W   = 11;
   localparam int GRP_W     = 12;
   localparam int GROUPS_W  = GRP_W + 1;
   localparam int ROW_W     = DIM_BITS;
   localparam int LANE_W    = GSIZE_W - 1;
   localparam int POS_W     = 32;
   localparam int IDX_W     = 32;
   localparam int CHANNEL_W = GRP_W + GSIZE_W;
   localparam int PIXEL_W   = 24;
   localparam int PLANE_W   = 2 * DIM_W - 1;
   localparam int PADC_W    = 13;
   localparam int VOL_W     = PADC_W + PLANE_W;
   localparam int TOTAL_W   = VOL_W + BATCH_W;
   localparam int DIV_W     = 13;
   localparam int REM_W     = GSIZE_W + 1;
   localparam int DIVCNT_W  = 4;

   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = POS_W + IDX_W;
   localparam int RSP_TUSER_W  = 2;

   localparam logic [CHAN_W-1:0]  MAX_CHANNELS = CHAN_W'(4096);
   localparam logic [DIM_W-1:0]   MAX_DIM      = DIM_W'(1) << DIM_BITS;
   localparam logic [GSIZE_W-1:0] MAX_GROUP    = GSIZE_W'(1024);

   localparam logic [BATCH_W-1:0] RST_BATCH_COUNT = BATCH_W'(1);
   localparam logic [CHAN_W-1:0]  RST_CHANNELS    = CHAN_W'(1);
   localparam logic [DIM_W-1:0]   RST_HEIGHT      = DIM_W'(1);
   localparam logic [DIM_W-1:0]   RST_WIDTH       = DIM_W'(1);
   localparam logic [GSIZE_W-1:0] RST_GROUP_SIZE  = GSIZE_W'(64);

   typedef enum logic [2:0] {
      REG_BATCH_COUNT = 3'd0,
      REG_CHANNELS    = 3'd1,
      REG_HEIGHT      = 3'd2,
      REG_WIDTH       = 3'd3,
      REG_GROUP_SIZE  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [GRP_W-1:0]   group;
      logic [LANE_W-1:0]  lane;
      logic [BATCH_W-1:0] batch;
      logic [ROW_W-1:0]   row;
      logic [ROW_W-1:0]   col;
      logic [POS_W-1:0]   pos;
      logic               last;
      logic [IDX_W-1:0]   plane_stride;
      logic [IDX_W-1:0]   batch_stride;
   } walk_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 pad;
      logic [PIXEL_W-1:0]   pixel;
      logic [IDX_W-1:0]     batch_off;
      logic [IDX_W-1:0]     plane_stride;
      logic [POS_W-1:0]     pos;
      logic                 last;
   } offs_type;

   typedef struct packed {
      logic [IDX_W-1:0]   chan_off;
      logic [PIXEL_W-1:0] pixel;
      logic [IDX_W-1:0]   batch_off;
      logic               pad;
      logic [POS_W-1:0]   pos;
      logic               last;
   } sum_type;

   typedef struct packed {
      logic [POS_W-1:0] stream_pos;
      logic [IDX_W-1:0] tensor_index;
      logic             is_pad;
      logic             is_last;
   } result_type;

   function automatic logic [BATCH_W-1:0] clamp_batch(input logic [BATCH_W-1:0] v);
      return (v == '0) ? BATCH_W'(1) : v;
   endfunction

   function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
      return (v == '0) ? CHAN_W'(1) : ((v > MAX_CHANNELS) ? MAX_CHANNELS : v);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v == '0) ? DIM_W'(1) : ((v > MAX_DIM) ? MAX_DIM : v);
   endfunction

   function automatic logic [GSIZE_W-1:0] clamp_group(input logic [GSIZE_W-1:0] v);
      return (v == '0) ? GSIZE_W'(1) : ((v > MAX_GROUP) ? MAX_GROUP : v);
   endfunction

endpackage

// ===== src/channel_group_layout_address_gen.sv =====
// Channel-group layout address generator: walks a dense tensor in grouped
// stream order and emits one address word per request word.
// Depends on cgl_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_tvalid/tready   | tdata: restart
//  rsp     | out       | rsp_tvalid/tready   | tdata: stream_pos, tensor_index;
//          |           |                     | tuser: is_pad, overflow; tlast: is_last
//  csr     | in/out    | psel/penable/pready | batch_count, channels, height, width,
//          |           |                     | group_size at 0x0..0x10
//
// One request word per cycle while req_tready is high, that is outside the derive pass
// and while the input register can advance; a result word passes from the input register
// through the two offset multiplier stages to the result register.
// After reset and after every register write a derive pass (load step, 13-step group
// count divider, then three multiply steps) holds req_tready low.
// Stalls on rsp back up stage by stage; empty stages keep taking request words.
module channel_group_layout_address_gen (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cgl_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cgl_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [31:0] stream_pos,
                                                            // [63:32] tensor_index
   output logic [cgl_pkg::RSP_TUSER_W-1:0]     rsp_tuser,   // [0] is_pad, [1] overflow
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cgl_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [cgl_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [cgl_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [2:0] {
      SEQ_LOAD,
      SEQ_DIV,
      SEQ_MUL_A,
      SEQ_MUL_B,
      SEQ_MUL_C,
      SEQ_DONE
   } seq_state_type;

   // configuration
   logic [cgl_pkg::BATCH_W-1:0] batch_count_ff;
   logic [cgl_pkg::CHAN_W-1:0]  channels_ff;
   logic [cgl_pkg::DIM_W-1:0]   height_ff;
   logic [cgl_pkg::DIM_W-1:0]   width_ff;
   logic [cgl_pkg::GSIZE_W-1:0] group_size_ff;

   logic [cgl_pkg::BATCH_W-1:0] nb;
   logic [cgl_pkg::CHAN_W-1:0]  nc;
   logic [cgl_pkg::DIM_W-1:0]   nh;
   logic [cgl_pkg::DIM_W-1:0]   nw;
   logic [cgl_pkg::GSIZE_W-1:0] ng;

   logic                        csr_write;
   cgl_pkg::reg_index_type      csr_index;

   // derive pass
   seq_state_type                     seq_ff;
   logic [cgl_pkg::DIV_W-1:0]         quo_ff;
   logic [cgl_pkg::REM_W-1:0]         rem_ff;
   logic [cgl_pkg::DIVCNT_W-1:0]      div_ctr_ff;
   logic [cgl_pkg::GROUPS_W-1:0]      groups_ff;
   logic [cgl_pkg::PADC_W-1:0]        padc_ff;
   logic [cgl_pkg::PLANE_W-1:0]       plane_ff;
   logic [cgl_pkg::IDX_W-1:0]         batch_c_ff;
   logic [cgl_pkg::VOL_W-1:0]         vol_ff;
   logic                              overflow_ff;
   logic [cgl_pkg::REM_W-1:0]         rem_shift;
   logic                              rem_fits;
   logic [cgl_pkg::REM_W-1:0]         rem_diff;
   logic [cgl_pkg::DIV_W+cgl_pkg::GSIZE_W-1:0] padc_full;
   logic [2*cgl_pkg::DIM_W-1:0]       plane_full;
   logic [cgl_pkg::CHAN_W+cgl_pkg::PLANE_W-1:0] batch_full;
   logic [cgl_pkg::VOL_W-1:0]         vol_full;
   logic [cgl_pkg::TOTAL_W-1:0]       total_full;
   logic                              busy;

   // walk state
   logic [cgl_pkg::GRP_W-1:0]   group_ff;
   logic [cgl_pkg::LANE_W-1:0]  lane_ff;
   logic [cgl_pkg::BATCH_W-1:0] batch_ff;
   logic [cgl_pkg::ROW_W-1:0]   row_ff;
   logic [cgl_pkg::ROW_W-1:0]   col_ff;
   logic [cgl_pkg::POS_W-1:0]   pos_ff;
   logic [cgl_pkg::IDX_W-1:0]   plane_stride_ff;
   logic [cgl_pkg::IDX_W-1:0]   batch_stride_ff;

   logic [cgl_pkg::GRP_W-1:0]   group_in;
   logic [cgl_pkg::LANE_W-1:0]  lane_in;
   logic [cgl_pkg::BATCH_W-1:0] batch_in;
   logic [cgl_pkg::ROW_W-1:0]   row_in;
   logic [cgl_pkg::ROW_W-1:0]   col_in;
   logic [cgl_pkg::POS_W-1:0]   pos_in;

   logic                          restart;
   logic                          accept;
   logic [cgl_pkg::GRP_W-1:0]     grp_b;
   logic [cgl_pkg::LANE_W-1:0]    lane_b;
   logic [cgl_pkg::BATCH_W-1:0]   batch_b;
   logic [cgl_pkg::ROW_W-1:0]     row_b;
   logic [cgl_pkg::ROW_W-1:0]     col_b;
   logic [cgl_pkg::POS_W-1:0]     pos_b;
   logic [cgl_pkg::GROUPS_W-1:0]  grp_inc;
   logic [cgl_pkg::GSIZE_W-1:0]   lane_inc;
   logic [cgl_pkg::BATCH_W:0]     batch_inc;
   logic [cgl_pkg::DIM_W-1:0]     row_inc;
   logic [cgl_pkg::DIM_W-1:0]     col_inc;
   logic                          lane_wrap;
   logic                          col_wrap;
   logic                          row_wrap;
   logic                          batch_wrap;
   logic                          grp_wrap;
   logic                          row_step;
   logic                          batch_step;
   logic                          grp_step;
   logic                          walk_wrap;

   // pipeline
   cgl_pkg::walk_type   s1_ff, s1_in;
   cgl_pkg::offs_type   s2_ff, s2_in;
   cgl_pkg::sum_type    s3_ff, s3_in;
   cgl_pkg::result_type out_ff, out_in;
   logic                s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic                s1_rdy, s2_rdy, s3_rdy, out_rdy;

   logic [cgl_pkg::CHANNEL_W-1:0]               chan_full;
   logic [cgl_pkg::ROW_W+cgl_pkg::DIM_W-1:0]    pix_full;
   logic [cgl_pkg::BATCH_W+cgl_pkg::IDX_W-1:0]  boff_full;
   logic [cgl_pkg::CHANNEL_W+cgl_pkg::IDX_W-1:0] coff_full;
   logic [cgl_pkg::IDX_W-1:0]                   index_sum;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = cgl_pkg::reg_index_type'(csr_paddr[cgl_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff <= cgl_pkg::RST_BATCH_COUNT;
         channels_ff    <= cgl_pkg::RST_CHANNELS;
         height_ff      <= cgl_pkg::RST_HEIGHT;
         width_ff       <= cgl_pkg::RST_WIDTH;
         group_size_ff  <= cgl_pkg::RST_GROUP_SIZE;
      end else if (csr_write) begin
         unique case (csr_index)
            cgl_pkg::REG_BATCH_COUNT: batch_count_ff <= csr_pwdata[cgl_pkg::BATCH_W-1:0];
            cgl_pkg::REG_CHANNELS:    channels_ff    <= csr_pwdata[cgl_pkg::CHAN_W-1:0];
            cgl_pkg::REG_HEIGHT:      height_ff      <= csr_pwdata[cgl_pkg::DIM_W-1:0];
            cgl_pkg::REG_WIDTH:       width_ff       <= csr_pwdata[cgl_pkg::DIM_W-1:0];
            cgl_pkg::REG_GROUP_SIZE:  group_size_ff  <= csr_pwdata[cgl_pkg::GSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         cgl_pkg::REG_BATCH_COUNT: csr_prdata = cgl_pkg::DATA_W'(batch_count_ff);
         cgl_pkg::REG_CHANNELS:    csr_prdata = cgl_pkg::DATA_W'(channels_ff);
         cgl_pkg::REG_HEIGHT:      csr_prdata = cgl_pkg::DATA_W'(height_ff);
         cgl_pkg::REG_WIDTH:       csr_prdata = cgl_pkg::DATA_W'(width_ff);
         cgl_pkg::REG_GROUP_SIZE:  csr_prdata = cgl_pkg::DATA_W'(group_size_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign nb = cgl_pkg::clamp_batch(batch_count_ff);
   assign nc = cgl_pkg::clamp_chan(channels_ff);
   assign nh = cgl_pkg::clamp_dim(height_ff);
   assign nw = cgl_pkg::clamp_dim(width_ff);
   assign ng = cgl_pkg::clamp_group(group_size_ff);

   // ---------------------------------------------------------------- derive pass
   assign rem_shift  = {rem_ff[cgl_pkg::REM_W-2:0], quo_ff[cgl_pkg::DIV_W-1]};
   assign rem_fits   = rem_shift >= cgl_pkg::REM_W'(ng);
   assign rem_diff   = rem_shift - cgl_pkg::REM_W'(ng);
   assign padc_full  = (cgl_pkg::DIV_W+cgl_pkg::GSIZE_W)'(quo_ff)
                     * (cgl_pkg::DIV_W+cgl_pkg::GSIZE_W)'(ng);
   assign plane_full = (2*cgl_pkg::DIM_W)'(nh) * (2*cgl_pkg::DIM_W)'(nw);
   assign batch_full = (cgl_pkg::CHAN_W+cgl_pkg::PLANE_W)'(nc)
                     * (cgl_pkg::CHAN_W+cgl_pkg::PLANE_W)'(plane_ff);
   assign vol_full   = cgl_pkg::VOL_W'(padc_ff) * cgl_pkg::VOL_W'(plane_ff);
   assign total_full = cgl_pkg::TOTAL_W'(vol_ff) * cgl_pkg::TOTAL_W'(nb);
   assign busy       = seq_ff != SEQ_DONE;

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         seq_ff <= SEQ_LOAD;
      end else begin
         unique case (seq_ff)
            SEQ_LOAD: begin
               quo_ff     <= nc + cgl_pkg::DIV_W'(ng) - cgl_pkg::DIV_W'(1);
               rem_ff     <= '0;
               div_ctr_ff <= '0;
               seq_ff     <= SEQ_DIV;
            end
            SEQ_DIV: begin
               rem_ff     <= rem_fits ? rem_diff : rem_shift;
               quo_ff     <= {quo_ff[cgl_pkg::DIV_W-2:0], rem_fits};
               div_ctr_ff <= div_ctr_ff + cgl_pkg::DIVCNT_W'(1);
               if (div_ctr_ff == cgl_pkg::DIVCNT_W'(cgl_pkg::DIV_W - 1)) begin
                  seq_ff <= SEQ_MUL_A;
               end
            end
            SEQ_MUL_A: begin
               groups_ff <= quo_ff;
               padc_ff   <= padc_full[cgl_pkg::PADC_W-1:0];
               plane_ff  <= plane_full[cgl_pkg::PLANE_W-1:0];
               seq_ff    <= SEQ_MUL_B;
            end
            SEQ_MUL_B: begin
               batch_c_ff <= batch_full[cgl_pkg::IDX_W-1:0];
               vol_ff     <= vol_full;
               seq_ff     <= SEQ_MUL_C;
            end
            SEQ_MUL_C: begin
               overflow_ff <= total_full > (cgl_pkg::TOTAL_W'(1) << cgl_pkg::INDEX_BITS);
               seq_ff      <= SEQ_DONE;
            end
            SEQ_DONE: ;
            default: seq_ff <= SEQ_LOAD;
         endcase
      end
   end

   // ---------------------------------------------------------------- walk counters
   assign out_rdy    = !out_v_ff || rsp_tready;
   assign s3_rdy     = !s3_v_ff || out_rdy;
   assign s2_rdy     = !s2_v_ff || s3_rdy;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy && !busy;
   assign accept     = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   always_comb begin
      grp_b   = restart ? '0 : group_ff;
      lane_b  = restart ? '0 : lane_ff;
      batch_b = restart ? '0 : batch_ff;
      row_b   = restart ? '0 : row_ff;
      col_b   = restart ? '0 : col_ff;
      pos_b   = restart ? '0 : pos_ff;

      grp_inc   = cgl_pkg::GROUPS_W'(grp_b) + cgl_pkg::GROUPS_W'(1);
      lane_inc  = cgl_pkg::GSIZE_W'(lane_b) + cgl_pkg::GSIZE_W'(1);
      batch_inc = (cgl_pkg::BATCH_W+1)'(batch_b) + (cgl_pkg::BATCH_W+1)'(1);
      row_inc   = cgl_pkg::DIM_W'(row_b) + cgl_pkg::DIM_W'(1);
      col_inc   = cgl_pkg::DIM_W'(col_b) + cgl_pkg::DIM_W'(1);

      lane_wrap  = lane_inc >= ng;
      col_wrap   = col_inc >= nw;
      row_wrap   = row_inc >= nh;
      batch_wrap = batch_inc >= (cgl_pkg::BATCH_W+1)'(nb);
      grp_wrap   = grp_inc >= groups_ff;

      row_step   = lane_wrap && col_wrap;
      batch_step = row_step && row_wrap;
      grp_step   = batch_step && batch_wrap;
      walk_wrap  = grp_step && grp_wrap;

      lane_in  = lane_wrap ? '0 : lane_inc[cgl_pkg::LANE_W-1:0];
      col_in   = !lane_wrap ? col_b : (col_wrap ? '0 : col_inc[cgl_pkg::ROW_W-1:0]);
      row_in   = !row_step ? row_b : (row_wrap ? '0 : row_inc[cgl_pkg::ROW_W-1:0]);
      batch_in = !batch_step ? batch_b
               : (batch_wrap ? '0 : batch_inc[cgl_pkg::BATCH_W-1:0]);
      group_in = !grp_step ? grp_b : (grp_wrap ? '0 : grp_inc[cgl_pkg::GRP_W-1:0]);
      pos_in   = walk_wrap ? '0 : pos_b + cgl_pkg::POS_W'(1);

      s1_in.group        = grp_b;
      s1_in.lane         = lane_b;
      s1_in.batch        = batch_b;
      s1_in.row          = row_b;
      s1_in.col          = col_b;
      s1_in.pos          = pos_b;
      s1_in.last         = (grp_inc == groups_ff)
                        && (batch_inc == (cgl_pkg::BATCH_W+1)'(nb))
                        && (row_inc == nh) && (col_inc == nw) && (lane_inc == ng);
      s1_in.plane_stride = restart ? cgl_pkg::IDX_W'(plane_ff) : plane_stride_ff;
      s1_in.batch_stride = restart ? batch_c_ff : batch_stride_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff        <= '0;
         lane_ff         <= '0;
         batch_ff        <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         pos_ff          <= '0;
         plane_stride_ff <= '0;
         batch_stride_ff <= '0;
      end else if (accept) begin
         group_ff        <= group_in;
         lane_ff         <= lane_in;
         batch_ff        <= batch_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         pos_ff          <= pos_in;
         plane_stride_ff <= s1_in.plane_stride;
         batch_stride_ff <= s1_in.batch_stride;
      end
   end

   // ---------------------------------------------------------------- offset pipeline
   always_comb begin
      chan_full = cgl_pkg::CHANNEL_W'(s1_ff.group) * cgl_pkg::CHANNEL_W'(ng)
                + cgl_pkg::CHANNEL_W'(s1_ff.lane);
      pix_full  = (cgl_pkg::ROW_W+cgl_pkg::DIM_W)'(s1_ff.row)
                * (cgl_pkg::ROW_W+cgl_pkg::DIM_W)'(nw)
                + (cgl_pkg::ROW_W+cgl_pkg::DIM_W)'(s1_ff.col);
      boff_full = (cgl_pkg::BATCH_W+cgl_pkg::IDX_W)'(s1_ff.batch)
                * (cgl_pkg::BATCH_W+cgl_pkg::IDX_W)'(s1_ff.batch_stride);

      s2_in.channel      = chan_full;
      s2_in.pad          = chan_full >= cgl_pkg::CHANNEL_W'(nc);
      s2_in.pixel        = pix_full[cgl_pkg::PIXEL_W-1:0];
      s2_in.batch_off    = boff_full[cgl_pkg::IDX_W-1:0];
      s2_in.plane_stride = s1_ff.plane_stride;
      s2_in.pos          = s1_ff.pos;
      s2_in.last         = s1_ff.last;
   end

   always_comb begin
      coff_full = (cgl_pkg::CHANNEL_W+cgl_pkg::IDX_W)'(s2_ff.channel)
                * (cgl_pkg::CHANNEL_W+cgl_pkg::IDX_W)'(s2_ff.plane_stride);

      s3_in.chan_off  = coff_full[cgl_pkg::IDX_W-1:0];
      s3_in.pixel     = s2_ff.pixel;
      s3_in.batch_off = s2_ff.batch_off;
      s3_in.pad       = s2_ff.pad;
      s3_in.pos       = s2_ff.pos;
      s3_in.last      = s2_ff.last;
   end

   always_comb begin
      index_sum = s3_ff.batch_off + s3_ff.chan_off + cgl_pkg::IDX_W'(s3_ff.pixel);

      out_in.stream_pos   = s3_ff.pos;
      out_in.tensor_index = s3_ff.pad ? '0 : index_sum;
      out_in.is_pad       = s3_ff.pad;
      out_in.is_last      = s3_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= accept;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_rdy) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_rdy) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_rdy && s2_v_ff) begin
         s3_ff <= s3_in;
      end
      if (out_rdy && s3_v_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.tensor_index, out_ff.stream_pos};
   assign rsp_tuser  = {overflow_ff, out_ff.is_pad};
   assign rsp_tlast  = out_ff.is_last;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for channel_group_layout_address_gen: streams restart words, tracks
// the grouped walk in a shadow copy and checks every field of each address word.
// Depends on cgl_pkg and the generator RTL.
module tb_top;
   import cgl_pkg::*;

   typedef struct {
      logic [POS_W-1:0] stream_pos;
      logic [IDX_W-1:0] tensor_index;
      logic             is_pad;
      logic             is_last;
      logic             overflow;
   } addr_word_type;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int HOLD_CYCLES   = 250;
   localparam int RANDOM_PHASES = 12;
   localparam int HOLD_PHASE    = 4;
   localparam int MAX_PHASE     = 2;
   localparam int WIDE_PHASE    = 7;
   localparam int LIMIT_CYCLES  = 400000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]      csr_paddr   = '0;
   logic [DATA_W-1:0]      csr_pwdata  = '0;
   logic [DATA_W-1:0]      csr_prdata;
   logic                   csr_pready;

   logic [BATCH_W-1:0] cfg_batch  = RST_BATCH_COUNT;
   logic [CHAN_W-1:0]  cfg_chan   = RST_CHANNELS;
   logic [DIM_W-1:0]   cfg_height = RST_HEIGHT;
   logic [DIM_W-1:0]   cfg_width  = RST_WIDTH;
   logic [GSIZE_W-1:0] cfg_group  = RST_GROUP_SIZE;

   logic [GRP_W-1:0]   grp_ctr      = '0;
   logic [BATCH_W-1:0] bat_ctr      = '0;
   logic [ROW_W-1:0]   row_ctr      = '0;
   logic [ROW_W-1:0]   col_ctr      = '0;
   logic [LANE_W-1:0]  lane_ctr     = '0;
   logic [POS_W-1:0]   pos_ctr      = '0;
   logic [IDX_W-1:0]   plane_stride = '0;
   logic [IDX_W-1:0]   batch_stride = '0;

   logic          restart_q[$];
   addr_word_type addr_word_q[$];
   int            words_pushed  = 0;
   int            words_taken   = 0;
   int            fail_count    = 0;
   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   logic          hold_rsp      = 1'b0;
   logic          hold_go       = 1'b0;

   channel_group_layout_address_gen dut (.*);

   always #HALF_PERIOD clock = ~clock;

   function automatic longint unsigned size_or_one(input longint unsigned v,
                                                   input longint unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void check_field(input string name, input longint unsigned expected,
                                       input longint unsigned actual);
      if (expected != actual) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
         fail_count++;
      end
   endfunction

   task automatic predict_addr_word(input logic restart);
      longint unsigned nb, nc, nh, nw, ng, groups, chan, total;
      longint unsigned grp, bat, row, col, lane;
      longint unsigned chan_off, bat_off, pix;
      logic            wrap;
      addr_word_type   w;
      nb = size_or_one(cfg_batch, 64'hFFFF);
      nc = size_or_one(cfg_chan, 4096);
      nh = size_or_one(cfg_height, 64'd1 << DIM_BITS);
      nw = size_or_one(cfg_width, 64'd1 << DIM_BITS);
      ng = size_or_one(cfg_group, 1024);
      groups = (nc + ng - 1) / ng;
      if (restart) begin
         grp_ctr = '0;
         bat_ctr = '0;
         row_ctr = '0;
         col_ctr = '0;
         lane_ctr = '0;
         pos_ctr = '0;
         plane_stride = IDX_W'(nh * nw);
         batch_stride = IDX_W'(nc * nh * nw);
      end
      grp = grp_ctr;
      bat = bat_ctr;
      row = row_ctr;
      col = col_ctr;
      lane = lane_ctr;
      chan = grp * ng + lane;
      chan_off = (chan * plane_stride) & 64'hFFFF_FFFF;
      bat_off = (bat * batch_stride) & 64'hFFFF_FFFF;
      pix = (row * nw + col) & 64'hFF_FFFF;
      total = nb * groups * ng * nh * nw;
      w.stream_pos = pos_ctr;
      w.is_pad = (chan >= nc);
      w.tensor_index = w.is_pad ? '0 : IDX_W'(bat_off + chan_off + pix);
      w.is_last = (grp == groups - 1) && (bat == nb - 1) && (row == nh - 1) &&
                  (col == nw - 1) && (lane == ng - 1);
      w.overflow = (total > (64'd1 << INDEX_BITS));
      wrap = 1'b0;
      lane++;
      if (lane >= ng) begin
         lane = 0;
         col++;
         if (col >= nw) begin
            col = 0;
            row++;
            if (row >= nh) begin
               row = 0;
               bat++;
               if (bat >= nb) begin
                  bat = 0;
                  grp++;
                  if (grp >= groups) begin
                     grp = 0;
                     wrap = 1'b1;
                  end
               end
            end
         end
      end
      grp_ctr = GRP_W'(grp);
      bat_ctr = BATCH_W'(bat);
      row_ctr = ROW_W'(row);
      col_ctr = ROW_W'(col);
      lane_ctr = LANE_W'(lane);
      pos_ctr = wrap ? '0 : pos_ctr + 1'b1;
      addr_word_q.insert(addr_word_q.size(), w);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [DATA_W-1:0] value,
                             output logic [DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] stored;
      logic [DATA_W-1:0] readback;
      csr_access(idx, 1'b1, value, readback);
      case (idx)
         REG_BATCH_COUNT: begin
            cfg_batch = value[BATCH_W-1:0];
            stored = DATA_W'(cfg_batch);
         end
         REG_CHANNELS: begin
            cfg_chan = value[CHAN_W-1:0];
            stored = DATA_W'(cfg_chan);
         end
         REG_HEIGHT: begin
            cfg_height = value[DIM_W-1:0];
            stored = DATA_W'(cfg_height);
         end
         REG_WIDTH: begin
            cfg_width = value[DIM_W-1:0];
            stored = DATA_W'(cfg_width);
         end
         REG_GROUP_SIZE: begin
            cfg_group = value[GSIZE_W-1:0];
            stored = DATA_W'(cfg_group);
         end
         default: begin
            stored = '0;
         end
      endcase
      csr_access(idx, 1'b0, '0, readback);
      check_field($sformatf("register %s", idx.name()), stored, readback);
   endtask

   task automatic write_sizes(input logic [DATA_W-1:0] batches, input logic [DATA_W-1:0] chans,
                              input logic [DATA_W-1:0] rows, input logic [DATA_W-1:0] cols,
                              input logic [DATA_W-1:0] lanes);
      write_reg(REG_BATCH_COUNT, batches);
      write_reg(REG_CHANNELS, chans);
      write_reg(REG_HEIGHT, rows);
      write_reg(REG_WIDTH, cols);
      write_reg(REG_GROUP_SIZE, lanes);
   endtask

   task automatic push_word(input logic restart);
      restart_q.insert(restart_q.size(), restart);
      words_pushed++;
   endtask

   task automatic wait_idle();
      while (words_taken != words_pushed || addr_word_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_addr_word(req_tdata[0]);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (restart_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_TDATA_W'(restart_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      addr_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (addr_word_q.size() == 0) begin
               $error("address word with none outstanding");
               fail_count++;
            end else begin
               want = addr_word_q.pop_front();
               check_field("stream_pos", want.stream_pos, rsp_tdata[POS_W-1:0]);
               check_field("tensor_index", want.tensor_index, rsp_tdata[POS_W +: IDX_W]);
               check_field("is_pad", want.is_pad, rsp_tuser[0]);
               check_field("overflow", want.overflow, rsp_tuser[1]);
               check_field("is_last", want.is_last, rsp_tlast);
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : rsp_hold
      wait (hold_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : stimulus
      int phase;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // strides stay zero until the first restart
      write_reg(REG_GROUP_SIZE, 1);
      write_reg(REG_HEIGHT, 2);
      write_reg(REG_WIDTH, 3);
      repeat (4) push_word(1'b0);
      wait_idle();

      // one full walk with padded lanes, then wrap to position zero
      write_sizes(2, 3, 1, 2, 2);
      push_word(1'b1);
      repeat (16) push_word(1'b0);
      wait_idle();

      // zero sizes act as one
      write_sizes(0, 0, 0, 0, 0);
      push_word(1'b1);
      push_word(1'b0);
      wait_idle();

      // out-of-range sizes saturate; padded count overflows the index range
      write_sizes(16'hFFFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 11'h7FF);
      push_word(1'b1);
      push_word(1'b0);
      wait_idle();

      // change sizes mid-walk, keep the latched strides
      write_reg(REG_GROUP_SIZE, 3);
      write_reg(REG_CHANNELS, 4096);
      push_word(1'b0);
      push_word(1'b0);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct <= 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 60;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               stall_pct <= 60;
            end
            default: begin
               send_idle_pct <= 29;
               stall_pct <= 29;
            end
         endcase
         if (phase == MAX_PHASE)
            write_sizes(16'hFFFF, 4096, 4096, 4096, 1024);
         else if (phase == WIDE_PHASE)
            write_sizes($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         else
            write_sizes($urandom_range(0, 2), $urandom_range(0, 6), $urandom_range(1, 2),
                        $urandom_range(1, 3), $urandom_range(0, 4));
         if (phase == HOLD_PHASE) hold_go <= 1'b1;
         n = $urandom_range(30, 50);
         push_word($urandom_range(99) < 85);
         repeat (n - 1) push_word($urandom_range(99) < 4);
         wait_idle();
      end

      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(2 * HALF_PERIOD * LIMIT_CYCLES);
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cgl_pkg.sv
src/channel_group_layout_address_gen.sv
tb/tb_top.sv
